>>> design/isha_pkg.sv
// ----------------------------------------------------------------------------
// Iterated salted SHA-256 package
// Shared types, round constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package isha_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        ST_INGEST,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_REHASH,
        ST_EMIT
    } t_state;

    // Control handed from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic from_iv;
    } t_comp_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_comp_sts;

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [255:0] sha_iv();
        return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> design/isha_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload word per handshake between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface isha_stream_if #(parameter int unsigned W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/isha_in_if.sv
// ----------------------------------------------------------------------------
// Message byte interface
// Carries one message byte and its final-byte flag per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface isha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> design/isha_out_if.sv
// ----------------------------------------------------------------------------
// Digest word interface
// Carries one 64-bit digest word and its tags per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface isha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
    logic        length_error;
    modport source (output valid, output digest_word, output word_number,
                    output last_word, output length_error, input ready);
    modport sink (input valid, input digest_word, input word_number,
                  input last_word, input length_error, output ready);
endinterface
`default_nettype wire

>>> design/iterated_salted_sha256.sv
// ----------------------------------------------------------------------------
// Iterated salted SHA-256
// Hashes salt||password, rehashes the digest, emits four 64-bit words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          word
//  in        in   data_byte[8], last_byte                          message byte
//  out       out  digest_word[64], word_number[2], last_word,      digest part
//                 length_error
//  cfg       in   data[31] iteration_count                         register
//
//  A byte that neither fills a 64-byte block nor is the final byte is taken
//  with ready left high. A byte that fills a block drops ready while the
//  shared round unit compresses it (start, 64 rounds, feed-forward, done).
//  After the final byte, the padded block (two when the padding spills over)
//  and each extra iteration are compressed before the first word is valid.
//  Synchronous active-low reset; no clearing pass. Output stalls hold the word.
// ----------------------------------------------------------------------------
`default_nettype none
module iterated_salted_sha256 #(
    parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    isha_in_if.sink     i_in,
    isha_out_if.source  o_out,
    isha_stream_if.sink i_cfg
);
    localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);

    isha_pkg::t_state    r_state, n_state;
    isha_pkg::t_state    r_ret;
    isha_pkg::t_comp_ctl ctl;
    isha_pkg::t_comp_sts sts;
    logic [255:0]  chain;
    logic [255:0]  r_chain;
    logic [511:0]  r_blk;
    logic [CW-1:0] r_cnt;
    logic [30:0]   r_iter, r_left;
    logic          r_ovf, r_go, r_iv;
    logic [1:0]    r_word;
    logic          in_fire, out_fire, in_room, comp_entry;
    logic          in_ready, out_valid;
    logic [5:0]    pos;
    logic [8:0]    sh;
    logic [63:0]   bits;
    logic [63:0]   out_word;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign in_room    = (r_cnt < CW'(MAX_MESSAGE_BYTES));
    assign pos        = 6'(r_cnt);
    assign sh         = 9'd504 - {pos, 3'b000};
    assign bits       = 64'(r_cnt) << 3;
    assign comp_entry = (n_state == isha_pkg::ST_COMP) && (r_state != isha_pkg::ST_COMP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= 31'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_iter <= i_cfg.data[30:0];
        end
    end
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isha_pkg::ST_INGEST: begin
                if (in_fire) begin
                    if (in_room && pos == 6'd63) begin
                        n_state = isha_pkg::ST_COMP;
                    end else if (i_in.last_byte) begin
                        n_state = isha_pkg::ST_PAD;
                    end
                end
            end
            isha_pkg::ST_PAD: n_state = (pos >= 6'd56) ? isha_pkg::ST_COMP : isha_pkg::ST_LEN;
            isha_pkg::ST_LEN: n_state = isha_pkg::ST_COMP;
            isha_pkg::ST_COMP: begin
                if (sts.done) n_state = r_ret;
            end
            isha_pkg::ST_REHASH: begin
                n_state = (r_left == 31'd0) ? isha_pkg::ST_EMIT : isha_pkg::ST_COMP;
            end
            isha_pkg::ST_EMIT: begin
                if (out_fire && r_word == 2'd3) n_state = isha_pkg::ST_INGEST;
            end
            default: n_state = isha_pkg::ST_INGEST;
        endcase
    end

    always_comb begin
        in_ready    = (r_state == isha_pkg::ST_INGEST);
        out_valid   = (r_state == isha_pkg::ST_EMIT);
        ctl.start   = r_go;
        ctl.from_iv = r_iv;
        case (r_word)
            2'd0: out_word = r_chain[255:192];
            2'd1: out_word = r_chain[191:128];
            2'd2: out_word = r_chain[127:64];
            2'd3: out_word = r_chain[63:0];
            default: out_word = r_chain[63:0];
        endcase
    end

    isha_compress u_comp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_block(r_blk), .i_chain(r_chain), .o_sts(sts), .o_chain(chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isha_pkg::ST_INGEST;
            r_ret   <= isha_pkg::ST_INGEST;
            r_cnt <= '0; r_ovf <= 1'b0; r_left <= '0; r_word <= '0;
            r_go <= 1'b0; r_iv <= 1'b0;
            r_chain <= isha_pkg::sha_iv(); r_blk <= '0;
        end else begin
            r_state <= n_state;
            // The start strobe is registered, so the round unit starts once the block register has settled.
            r_go    <= comp_entry;
            if (comp_entry) begin
                r_iv <= (r_state == isha_pkg::ST_REHASH);
                if (r_state == isha_pkg::ST_INGEST) begin
                    r_ret <= i_in.last_byte ? isha_pkg::ST_PAD : isha_pkg::ST_INGEST;
                end else if (r_state == isha_pkg::ST_PAD) begin
                    r_ret <= isha_pkg::ST_LEN;
                end else begin
                    r_ret <= isha_pkg::ST_REHASH;
                end
            end
            unique case (r_state)
                isha_pkg::ST_INGEST: begin
                    if (in_fire) begin
                        if (in_room) begin
                            r_blk <= r_blk | (512'(i_in.data_byte) << sh);
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                isha_pkg::ST_PAD: begin
                    r_blk <= r_blk | (512'(8'h80) << sh);
                end
                isha_pkg::ST_LEN: begin
                    r_blk[63:0] <= bits;
                    r_left <= (r_iter == 31'd0) ? 31'd0 : r_iter - 31'd1;
                end
                isha_pkg::ST_COMP: begin
                    if (sts.done) begin
                        r_chain <= chain;
                        r_blk   <= '0;
                    end
                end
                isha_pkg::ST_REHASH: begin
                    if (r_left != 31'd0) begin
                        r_blk  <= {r_chain, 32'h80000000, 192'd0, 32'd256};
                        r_left <= r_left - 31'd1;
                    end
                end
                isha_pkg::ST_EMIT: begin
                    if (out_fire) begin
                        r_word <= r_word + 2'd1;
                        if (r_word == 2'd3) begin
                            r_cnt <= '0; r_ovf <= 1'b0; r_left <= '0;
                            r_chain <= isha_pkg::sha_iv(); r_blk <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.digest_word  = out_word;
    assign o_out.word_number  = r_word;
    assign o_out.last_word    = (r_word == 2'd3);
    assign o_out.length_error = r_ovf;

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("byte taken while emitting");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_MESSAGE_BYTES)) else $error("byte count past bound");
    a_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_word == 2'd3) |=> (r_cnt == '0 && !r_ovf))
        else $error("message state not cleared");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.digest_word)
        && $stable(o_out.word_number))) else $error("stalled word changed");
endmodule
`default_nettype wire

>>> design/isha_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One round per cycle with a rolling 16-word message schedule.
// ----------------------------------------------------------------------------
`default_nettype none
module isha_compress (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire isha_pkg::t_comp_ctl i_ctl,
    input  wire logic [511:0]        i_block,
    input  wire logic [255:0]        i_chain,
    output isha_pkg::t_comp_sts      o_sts,
    output logic [255:0]             o_chain
);
    logic         r_busy, n_busy;
    logic         r_done;
    logic [5:0]   r_round;
    logic         r_fin;
    logic [511:0] r_w;
    logic [255:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [31:0]  t1, t2, s0, s1, w_new, w_cur;
    logic [255:0] base;

    assign base  = i_ctl.from_iv ? isha_pkg::sha_iv() : i_chain;
    assign w_cur = r_w[511:480];
    assign s0 = isha_pkg::rotr(r_w[479:448], 7) ^ isha_pkg::rotr(r_w[479:448], 18)
              ^ (r_w[479:448] >> 3);
    assign s1 = isha_pkg::rotr(r_w[63:32], 17) ^ isha_pkg::rotr(r_w[63:32], 19)
              ^ (r_w[63:32] >> 10);
    assign w_new = w_cur + s0 + r_w[223:192] + s1;
    assign t1 = r_hh + (isha_pkg::rotr(r_e, 6) ^ isha_pkg::rotr(r_e, 11)
              ^ isha_pkg::rotr(r_e, 25)) + ((r_e & r_f) ^ (~r_e & r_g))
              + isha_pkg::sha_k(r_round) + w_cur;
    assign t2 = (isha_pkg::rotr(r_a, 2) ^ isha_pkg::rotr(r_a, 13)
              ^ isha_pkg::rotr(r_a, 22)) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_comb begin
        n_busy = r_busy;
        if (i_ctl.start) begin
            n_busy = 1'b1;
        end else if (r_fin) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_fin;
            r_fin  <= r_busy && !r_fin && (r_round == 6'd63);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_h <= base;
            r_w <= i_block;
            r_round <= '0;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh} <= base;
        end else if (r_busy && !r_fin) begin
            r_round <= r_round + 6'd1;
            r_w <= {r_w[479:0], w_new};
            r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end else if (r_fin) begin
            // Feed-forward add of the working variables into the chain.
            r_h <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                    r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                    r_h[63:32] + r_g, r_h[31:0] + r_hh};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_chain    = r_h;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running compression");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy) else $error("compression restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held for more than one cycle");
endmodule
`default_nettype wire
